>>> sv/efr_pkg.sv
// Shared types, marker codes and helpers for the escaped frame receiver.
// Depends on nothing; used by every module in sv/.
package efr_pkg;

    // Buffer depth; positions wrap to 0 on reaching it (32..256).
    localparam int BUF_DEPTH = 256;
    localparam int BYTE_W    = 8;
    localparam int TYPE_W    = 5;

    localparam logic [BYTE_W-1:0] MARK_ESC     = 8'hFE;
    localparam logic [BYTE_W-1:0] MARK_START   = 8'hFB;
    localparam logic [BYTE_W-1:0] MARK_END     = 8'hFA;
    localparam logic [TYPE_W-1:0] TYPE_INFO    = 5'h04;
    localparam logic [TYPE_W-1:0] TYPE_REQUEST = 5'h1E;
    localparam logic [TYPE_W-1:0] TYPE_RESET   = 5'h1F;
    localparam logic [BYTE_W-1:0] LIMIT_RESET  = 8'd21;
    localparam logic [BYTE_W-1:0] TYPE_POS     = 8'd3;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_SHORT    = 2'd1,
        EV_ACCEPTED = 2'd2,
        EV_REJECTED = 2'd3
    } t_event;

    // One byte held between the input register and the decode stage.
    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data;
    } t_beat;

    function automatic logic [BYTE_W-1:0] advance(input logic [BYTE_W-1:0] pos);
        logic [BYTE_W-1:0] res;
        if (pos == BYTE_W'(BUF_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = pos + 1'b1;
        end
        return res;
    endfunction

endpackage

>>> sv/efr_in_reg.sv
// Input register stage: captures one received byte per beat.
// Depends on efr_pkg.
module efr_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rx_valid,
    input  logic [efr_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_rx_stall,
    input  logic                        i_take,
    output efr_pkg::t_beat              o_beat
);

    logic                       r_vld;
    logic [efr_pkg::BYTE_W-1:0] r_data;
    logic                       load;

    // Stage frees up when empty or when the decode stage takes it this cycle.
    assign o_rx_stall = r_vld & ~i_take;
    assign load       = i_rx_valid & ~o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_rx_byte;
        end
    end

    assign o_beat.vld  = r_vld;
    assign o_beat.data = r_data;

endmodule

>>> sv/efr_core.sv
// Marker decode, frame state, limit register and result register.
// Depends on efr_pkg.
module efr_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [efr_pkg::BYTE_W-1:0]  i_cfg_data,
    input  efr_pkg::t_beat              i_beat,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [efr_pkg::BYTE_W-1:0]  o_wr_index,
    output logic [efr_pkg::BYTE_W-1:0]  o_wr_byte,
    output logic                        o_frame_start,
    output logic [1:0]                  o_frame_event,
    output logic [efr_pkg::BYTE_W-1:0]  o_frame_length,
    output logic [efr_pkg::TYPE_W-1:0]  o_frame_type
);

    logic [efr_pkg::BYTE_W-1:0] r_short_limit;
    logic                       r_marker_armed, n_marker_armed;
    logic                       r_in_frame,     n_in_frame;
    logic [efr_pkg::BYTE_W-1:0] r_write_pos,    n_write_pos;
    logic [efr_pkg::BYTE_W-1:0] r_type_byte,    n_type_byte;

    logic                       r_out_valid;
    logic [efr_pkg::BYTE_W-1:0] r_wr_index;
    logic [efr_pkg::BYTE_W-1:0] r_wr_byte;
    logic                       r_frame_start,  n_frame_start;
    efr_pkg::t_event            r_frame_event,  n_frame_event;
    logic [efr_pkg::BYTE_W-1:0] r_frame_length, n_frame_length;
    logic [efr_pkg::TYPE_W-1:0] r_frame_type,   n_frame_type;

    logic                       out_free;
    logic [efr_pkg::BYTE_W-1:0] b;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign o_take   = i_beat.vld & out_free;
    assign b        = i_beat.data;

    always_comb begin
        n_marker_armed = r_marker_armed;
        n_in_frame     = r_in_frame;
        n_write_pos    = efr_pkg::advance(r_write_pos);
        n_type_byte    = (r_write_pos == efr_pkg::TYPE_POS) ? b : r_type_byte;
        n_frame_type   = n_type_byte[efr_pkg::BYTE_W-1:3];
        n_frame_start  = 1'b0;
        n_frame_event  = efr_pkg::EV_NONE;
        n_frame_length = '0;

        if (!r_marker_armed) begin
            if (b == efr_pkg::MARK_ESC) begin
                n_marker_armed = 1'b1;
            end
        end else if (b == efr_pkg::MARK_START) begin
            n_frame_start  = 1'b1;
            n_marker_armed = 1'b0;
            n_in_frame     = 1'b1;
            n_write_pos    = efr_pkg::advance(efr_pkg::BYTE_W'(1));
        end else if (b == efr_pkg::MARK_END && r_in_frame) begin
            n_in_frame     = 1'b0;
            n_marker_armed = 1'b0;
            n_frame_length = r_write_pos;
            if (r_write_pos < r_short_limit) begin
                n_frame_event = efr_pkg::EV_SHORT;
            end else if (n_frame_type == efr_pkg::TYPE_INFO ||
                         n_frame_type == efr_pkg::TYPE_REQUEST ||
                         n_frame_type == efr_pkg::TYPE_RESET) begin
                n_frame_event = efr_pkg::EV_ACCEPTED;
            end else begin
                n_frame_event = efr_pkg::EV_REJECTED;
            end
        end else if (b == efr_pkg::MARK_ESC && r_in_frame) begin
            // stuffed escape: next byte overwrites this position
            n_marker_armed = 1'b0;
            n_write_pos    = r_write_pos;
        end
        // any other byte after an escape leaves the marker armed
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit  <= efr_pkg::LIMIT_RESET;
            r_marker_armed <= 1'b0;
            r_in_frame     <= 1'b0;
            r_write_pos    <= '0;
            r_type_byte    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_short_limit <= i_cfg_data;
            end
            if (o_take) begin
                r_marker_armed <= n_marker_armed;
                r_in_frame     <= n_in_frame;
                r_write_pos    <= n_write_pos;
                r_type_byte    <= n_type_byte;
                r_out_valid    <= 1'b1;
            end else if (out_free) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_wr_index     <= r_write_pos;
            r_wr_byte      <= b;
            r_frame_start  <= n_frame_start;
            r_frame_event  <= n_frame_event;
            r_frame_length <= n_frame_length;
            r_frame_type   <= n_frame_type;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_wr_index     = r_wr_index;
    assign o_wr_byte      = r_wr_byte;
    assign o_frame_start  = r_frame_start;
    assign o_frame_event  = r_frame_event;
    assign o_frame_length = r_frame_length;
    assign o_frame_type   = r_frame_type;

endmodule

>>> sv/escaped_frame_receiver.sv
// Top level of the escaped frame receiver: input register plus decode/result stage.
// Depends on efr_pkg, efr_in_reg and efr_core.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+---------------------------------------------
//  rx      | i_rx_valid  | o_rx_stall   | i_rx_byte
//  out     | o_out_valid | i_out_stall  | o_wr_index o_wr_byte o_frame_start
//          |             |              | o_frame_event o_frame_length o_frame_type
//  cfg     | i_cfg_we    | -            | i_cfg_data (short frame limit)
//
// One beat in and one result out per cycle when neither side stalls.
// A result is registered: each accepted byte passes through the input register, then the result register.
// Synchronous active-low reset clears the frame state and sets the limit to 21.
// An output stall backs up into the input register; o_rx_stall rises only when it is full.
module escaped_frame_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [efr_pkg::BYTE_W-1:0]  i_cfg_data,
    input  logic                        i_rx_valid,
    output logic                        o_rx_stall,
    input  logic [efr_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [efr_pkg::BYTE_W-1:0]  o_wr_index,
    output logic [efr_pkg::BYTE_W-1:0]  o_wr_byte,
    output logic                        o_frame_start,
    output logic [1:0]                  o_frame_event,
    output logic [efr_pkg::BYTE_W-1:0]  o_frame_length,
    output logic [efr_pkg::TYPE_W-1:0]  o_frame_type
);

    efr_pkg::t_beat beat;
    logic           take;

    efr_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_stall (o_rx_stall),
        .i_take     (take),
        .o_beat     (beat)
    );

    efr_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_beat         (beat),
        .o_take         (take),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_wr_index     (o_wr_index),
        .o_wr_byte      (o_wr_byte),
        .o_frame_start  (o_frame_start),
        .o_frame_event  (o_frame_event),
        .o_frame_length (o_frame_length),
        .o_frame_type   (o_frame_type)
    );

    a_start_not_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_start |-> o_frame_event == efr_pkg::EV_NONE)
        else $error("start and close reported on the same beat");

    a_start_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_start |-> o_wr_byte == efr_pkg::MARK_START)
        else $error("frame start without start marker byte");

    a_close_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_event != efr_pkg::EV_NONE
        |-> o_wr_byte == efr_pkg::MARK_END && o_frame_length == o_wr_index)
        else $error("frame close inconsistent with written byte or index");

    a_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_event == efr_pkg::EV_NONE |-> o_frame_length == '0)
        else $error("frame length set without a close event");

    a_rx_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while the result side can move");

endmodule
